@@ rtl/bcrs_pkg.sv @@
// ---------------------------------------------------------------------------
// bcrs_pkg: shared types and constants of the best chi2 rotation selector
// Widths, register indexes, register reset values, config struct, FSM states.
// ---------------------------------------------------------------------------
`default_nettype none

package bcrs_pkg;

    localparam int ROTATIONS  = 3;
    localparam int MASS_BITS  = 18;
    localparam int WEIGHT_BITS = 32;
    localparam int ROT_BITS   = (ROTATIONS > 1) ? $clog2(ROTATIONS) : 1;
    localparam int OPND_BITS  = 32;
    localparam int SQ_BITS    = 2 * OPND_BITS;
    localparam int NUM_REGS   = 8;
    localparam int IDX_BITS   = $clog2(NUM_REGS);

    localparam logic [ROT_BITS-1:0] ROT_LAST = ROT_BITS'(ROTATIONS - 1);

    localparam logic [IDX_BITS-1:0] REG_PI0_MASS      = IDX_BITS'(0);
    localparam logic [IDX_BITS-1:0] REG_ETA_MASS      = IDX_BITS'(1);
    localparam logic [IDX_BITS-1:0] REG_PI0_INV_SIGMA = IDX_BITS'(2);
    localparam logic [IDX_BITS-1:0] REG_ETA_INV_SIGMA = IDX_BITS'(3);
    localparam logic [IDX_BITS-1:0] REG_PI0_WIN_LOW   = IDX_BITS'(4);
    localparam logic [IDX_BITS-1:0] REG_PI0_WIN_HIGH  = IDX_BITS'(5);
    localparam logic [IDX_BITS-1:0] REG_ETA_WIN_LOW   = IDX_BITS'(6);
    localparam logic [IDX_BITS-1:0] REG_ETA_WIN_HIGH  = IDX_BITS'(7);

    localparam logic [MASS_BITS-1:0] RST_PI0_MASS      = MASS_BITS'(8847);
    localparam logic [MASS_BITS-1:0] RST_ETA_MASS      = MASS_BITS'(35848);
    localparam logic [MASS_BITS-1:0] RST_PI0_INV_SIGMA = MASS_BITS'(25600);
    localparam logic [MASS_BITS-1:0] RST_ETA_INV_SIGMA = MASS_BITS'(5120);
    localparam logic [MASS_BITS-1:0] RST_PI0_WIN_LOW   = MASS_BITS'(8192);
    localparam logic [MASS_BITS-1:0] RST_PI0_WIN_HIGH  = MASS_BITS'(9503);
    localparam logic [MASS_BITS-1:0] RST_ETA_WIN_LOW   = MASS_BITS'(32768);
    localparam logic [MASS_BITS-1:0] RST_ETA_WIN_HIGH  = MASS_BITS'(39322);

    typedef struct packed {
        logic [MASS_BITS-1:0] pi0_mass;
        logic [MASS_BITS-1:0] eta_mass;
        logic [MASS_BITS-1:0] pi0_inv_sigma;
        logic [MASS_BITS-1:0] eta_inv_sigma;
        logic [MASS_BITS-1:0] pi0_win_low;
        logic [MASS_BITS-1:0] pi0_win_high;
        logic [MASS_BITS-1:0] eta_win_low;
        logic [MASS_BITS-1:0] eta_win_high;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ETA_PULL,
        S_ETA_SQ,
        S_PI0_PULL,
        S_PI0_SQ,
        S_DECIDE
    } t_state;

endpackage

`default_nettype wire

@@ rtl/bcrs_regs.sv @@
// ---------------------------------------------------------------------------
// bcrs_regs: configuration register file
// Eight write-only registers loaded through a plain write port.
// ---------------------------------------------------------------------------
`default_nettype none

module bcrs_regs
    import bcrs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [MASS_BITS-1:0] i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pi0_mass      <= RST_PI0_MASS;
            r_cfg.eta_mass      <= RST_ETA_MASS;
            r_cfg.pi0_inv_sigma <= RST_PI0_INV_SIGMA;
            r_cfg.eta_inv_sigma <= RST_ETA_INV_SIGMA;
            r_cfg.pi0_win_low   <= RST_PI0_WIN_LOW;
            r_cfg.pi0_win_high  <= RST_PI0_WIN_HIGH;
            r_cfg.eta_win_low   <= RST_ETA_WIN_LOW;
            r_cfg.eta_win_high  <= RST_ETA_WIN_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PI0_MASS:      r_cfg.pi0_mass      <= i_cfg_data;
                REG_ETA_MASS:      r_cfg.eta_mass      <= i_cfg_data;
                REG_PI0_INV_SIGMA: r_cfg.pi0_inv_sigma <= i_cfg_data;
                REG_ETA_INV_SIGMA: r_cfg.eta_inv_sigma <= i_cfg_data;
                REG_PI0_WIN_LOW:   r_cfg.pi0_win_low   <= i_cfg_data;
                REG_PI0_WIN_HIGH:  r_cfg.pi0_win_high  <= i_cfg_data;
                REG_ETA_WIN_LOW:   r_cfg.eta_win_low   <= i_cfg_data;
                REG_ETA_WIN_HIGH:  r_cfg.eta_win_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/bcrs_mul.sv @@
// ---------------------------------------------------------------------------
// bcrs_mul: shared registered multiplier
// One unsigned 32x32 product per enabled cycle, result registered.
// ---------------------------------------------------------------------------
`default_nettype none

module bcrs_mul
    import bcrs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [OPND_BITS-1:0] i_a,
    input  wire logic [OPND_BITS-1:0] i_b,
    output logic      [SQ_BITS-1:0]   o_prod
);

    logic [SQ_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= SQ_BITS'(i_a) * SQ_BITS'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ rtl/best_chi2_rotation_select_unit.sv @@
// ---------------------------------------------------------------------------
// best_chi2_rotation_select_unit: picks the lowest-chi2 rotation of an event
// Scores each rotation request and emits the chosen one after the last.
// ---------------------------------------------------------------------------
// Each event is ROTATIONS consecutive requests. A request is scored in full
// before the next can be accepted: one shared 32x32 multiplier is used four
// times in sequence (eta pull, its square, pi0 pull, its square), then a
// decide step sums, saturates and compares against the best so far. On the
// last rotation of an event the result is loaded into an output register;
// if that register still holds an untaken result, the block waits for it.
// The square of a pull of 2^32 or more, and the sum, saturate at 2^64-1.
// Configuration writes take effect at once and belong between requests,
// while o_in_ready is high; a write during scoring affects the later steps.
`default_nettype none

module best_chi2_rotation_select_unit
    import bcrs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [MASS_BITS-1:0]   i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [MASS_BITS-1:0]   i_three_body_mass,
    input  wire logic [MASS_BITS-1:0]   i_photon_pair_mass,
    input  wire logic [MASS_BITS-1:0]   i_full_mass,
    input  wire logic [WEIGHT_BITS-1:0] i_event_weight,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [MASS_BITS-1:0]        o_chosen_full_mass,
    output logic [WEIGHT_BITS-1:0]      o_chosen_weight,
    output logic                        o_kept
);

    t_cfg w_cfg;

    bcrs_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    logic                 w_mul_en;
    logic [OPND_BITS-1:0] w_mul_a;
    logic [OPND_BITS-1:0] w_mul_b;
    logic [SQ_BITS-1:0]   w_prod;

    bcrs_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    t_state                r_state, n_state;
    logic [MASS_BITS-1:0]  r_m3, n_m3;
    logic [MASS_BITS-1:0]  r_m2, n_m2;
    logic [MASS_BITS-1:0]  r_mf, n_mf;
    logic [WEIGHT_BITS-1:0] r_w, n_w;
    logic                  r_eta_sat, n_eta_sat;
    logic                  r_pi0_sat, n_pi0_sat;
    logic [SQ_BITS-1:0]    r_eta_term, n_eta_term;
    logic [ROT_BITS-1:0]   r_rot_idx, n_rot_idx;
    logic [SQ_BITS-1:0]    r_best_score, n_best_score;
    logic [MASS_BITS-1:0]  r_best_full, n_best_full;
    logic [MASS_BITS-1:0]  r_best_m3, n_best_m3;
    logic [MASS_BITS-1:0]  r_best_m2, n_best_m2;
    logic [WEIGHT_BITS-1:0] r_best_w, n_best_w;
    logic                  r_out_valid, n_out_valid;
    logic [MASS_BITS-1:0]  r_out_full, n_out_full;
    logic [WEIGHT_BITS-1:0] r_out_w, n_out_w;
    logic                  r_out_kept, n_out_kept;

    logic [MASS_BITS-1:0]  w_eta_mag;
    logic [MASS_BITS-1:0]  w_pi0_mag;
    logic [SQ_BITS-1:0]    w_pi0_term;
    logic [SQ_BITS:0]      w_sum;
    logic [SQ_BITS-1:0]    w_chi2;
    logic                  w_take;
    logic                  w_last;
    logic                  w_out_free;
    logic [MASS_BITS-1:0]  w_sel_m3;
    logic [MASS_BITS-1:0]  w_sel_m2;

    assign w_eta_mag = (r_m3 >= w_cfg.eta_mass) ? (r_m3 - w_cfg.eta_mass)
                                                : (w_cfg.eta_mass - r_m3);
    assign w_pi0_mag = (r_m2 >= w_cfg.pi0_mass) ? (r_m2 - w_cfg.pi0_mass)
                                                : (w_cfg.pi0_mass - r_m2);

    assign w_pi0_term = r_pi0_sat ? '1 : w_prod;
    assign w_sum      = {1'b0, r_eta_term} + {1'b0, w_pi0_term};
    assign w_chi2     = w_sum[SQ_BITS] ? '1 : w_sum[SQ_BITS-1:0];
    assign w_take     = (r_rot_idx == '0) || (w_chi2 < r_best_score);
    assign w_last     = (r_rot_idx == ROT_LAST);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_sel_m3   = w_take ? r_m3 : r_best_m3;
    assign w_sel_m2   = w_take ? r_m2 : r_best_m2;

    always_comb begin
        n_state      = r_state;
        n_m3         = r_m3;
        n_m2         = r_m2;
        n_mf         = r_mf;
        n_w          = r_w;
        n_eta_sat    = r_eta_sat;
        n_pi0_sat    = r_pi0_sat;
        n_eta_term   = r_eta_term;
        n_rot_idx    = r_rot_idx;
        n_best_score = r_best_score;
        n_best_full  = r_best_full;
        n_best_m3    = r_best_m3;
        n_best_m2    = r_best_m2;
        n_best_w     = r_best_w;
        n_out_valid  = r_out_valid;
        n_out_full   = r_out_full;
        n_out_w      = r_out_w;
        n_out_kept   = r_out_kept;
        w_mul_en     = 1'b0;
        w_mul_a      = OPND_BITS'(w_eta_mag);
        w_mul_b      = OPND_BITS'(w_cfg.eta_inv_sigma);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_m3    = i_three_body_mass;
                    n_m2    = i_photon_pair_mass;
                    n_mf    = i_full_mass;
                    n_w     = i_event_weight;
                    n_state = S_ETA_PULL;
                end
            end
            S_ETA_PULL: begin
                w_mul_en = 1'b1;
                n_state  = S_ETA_SQ;
            end
            S_ETA_SQ: begin
                w_mul_en  = 1'b1;
                w_mul_a   = w_prod[OPND_BITS-1:0];
                w_mul_b   = w_prod[OPND_BITS-1:0];
                n_eta_sat = (w_prod[SQ_BITS-1:OPND_BITS] != '0);
                n_state   = S_PI0_PULL;
            end
            S_PI0_PULL: begin
                w_mul_en   = 1'b1;
                w_mul_a    = OPND_BITS'(w_pi0_mag);
                w_mul_b    = OPND_BITS'(w_cfg.pi0_inv_sigma);
                n_eta_term = r_eta_sat ? '1 : w_prod;
                n_state    = S_PI0_SQ;
            end
            S_PI0_SQ: begin
                w_mul_en  = 1'b1;
                w_mul_a   = w_prod[OPND_BITS-1:0];
                w_mul_b   = w_prod[OPND_BITS-1:0];
                n_pi0_sat = (w_prod[SQ_BITS-1:OPND_BITS] != '0);
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                if (!w_last || w_out_free) begin
                    if (w_take) begin
                        n_best_score = w_chi2;
                        n_best_full  = r_mf;
                        n_best_m3    = r_m3;
                        n_best_m2    = r_m2;
                        n_best_w     = r_w;
                    end
                    if (w_last) begin
                        n_rot_idx    = '0;
                        n_best_score = '1;
                        n_out_valid  = 1'b1;
                        n_out_full   = w_take ? r_mf : r_best_full;
                        n_out_w      = w_take ? r_w : r_best_w;
                        n_out_kept   = (w_sel_m3 >= w_cfg.eta_win_low)
                                    && (w_sel_m3 <= w_cfg.eta_win_high)
                                    && (w_sel_m2 >= w_cfg.pi0_win_low)
                                    && (w_sel_m2 <= w_cfg.pi0_win_high);
                    end else begin
                        n_rot_idx = r_rot_idx + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rot_idx    <= '0;
            r_best_score <= '1;
            r_best_full  <= '0;
            r_best_m3    <= '0;
            r_best_m2    <= '0;
            r_best_w     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rot_idx    <= n_rot_idx;
            r_best_score <= n_best_score;
            r_best_full  <= n_best_full;
            r_best_m3    <= n_best_m3;
            r_best_m2    <= n_best_m2;
            r_best_w     <= n_best_w;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m3       <= n_m3;
        r_m2       <= n_m2;
        r_mf       <= n_mf;
        r_w        <= n_w;
        r_eta_sat  <= n_eta_sat;
        r_pi0_sat  <= n_pi0_sat;
        r_eta_term <= n_eta_term;
        r_out_full <= n_out_full;
        r_out_w    <= n_out_w;
        r_out_kept <= n_out_kept;
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_chosen_full_mass = r_out_full;
    assign o_chosen_weight    = r_out_w;
    assign o_kept             = r_out_kept;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_ETA_PULL))
        else $error("accepted request did not start scoring");

    a_rot_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rot_idx <= ROT_LAST))
        else $error("rotation index out of range");

    a_out_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DECIDE && $past(w_last)))
        else $error("result raised outside the last decide step");

    a_event_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (r_rot_idx == '0 && r_best_score == '1))
        else $error("event state not cleared after result");

endmodule

`default_nettype wire
